// ----- sv/ple_pkg.sv -----
// shared types and codes for the positional list engine
package ple_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned POS_W = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [4:0]              entry_count;
        logic                    is_empty;
        logic [1:0]              status;
    } t_result;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] position;
    } t_cell_ctl;

endpackage

// ----- sv/ple_cell.sv -----
// one list slot: holds an entry and shifts with its neighbours
module ple_cell import ple_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_entry,
    output logic signed [VAL_W-1:0] o_peek
);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    at_pos;
    logic                    above_pos;

    assign at_pos    = (32'(i_ctl.position) == 32'(IDX));
    assign above_pos = (32'(IDX) > 32'(i_ctl.position));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (above_pos) begin
                n_entry = i_left;
            end else if (at_pos) begin
                n_entry = i_value;
            end
        end else if (i_ctl.del) begin
            if (above_pos || at_pos) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_peek  = at_pos ? r_entry : '0;

endmodule

// ----- sv/positional_list_engine.sv -----
// positional list engine: bounded ordered list with insert, delete, peek and clear
// the result strobe is registered and comes in the cycle after the transaction is accepted
// throughput: one transaction per cycle, busy stays low; every cell shifts in parallel
// reset: synchronous, clears the count and the result strobe; entry contents are kept
// the result strobe is high for one cycle only, as the receiver cannot stall
module positional_list_engine import ple_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned KW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_strobe;
    t_result                 r_result;
    t_result                 n_result;
    t_cell_ctl               cell_ctl;
    logic signed [VAL_W-1:0] entry [CAPACITY];
    logic signed [VAL_W-1:0] peek  [CAPACITY];
    logic signed [VAL_W-1:0] peek_or;
    logic [KW-1:0]           pos_k;
    logic [KW-1:0]           cnt_k;
    logic                    full;

    assign pos_k = KW'(i_cmd.position);
    assign cnt_k = KW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VAL_W-1:0] left_d;
            logic signed [VAL_W-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = i_cmd.value;
            end else begin : g_mid_l
                assign left_d = entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_d = entry[g];
            end else begin : g_mid_r
                assign right_d = entry[g+1];
            end
            ple_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_value (i_cmd.value),
                .i_left  (left_d),
                .i_right (right_d),
                .o_entry (entry[g]),
                .o_peek  (peek[g])
            );
        end
    endgenerate

    always_comb begin
        peek_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            peek_or = peek_or | peek[k];
        end
    end

    always_comb begin
        n_count             = r_count;
        n_result.read_value = '0;
        n_result.status     = ST_OK;
        cell_ctl.ins        = 1'b0;
        cell_ctl.del        = 1'b0;
        cell_ctl.position   = i_cmd.position;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (pos_k > cnt_k) begin
                    n_result.status = ST_RANGE;
                end else if (full) begin
                    n_result.status = ST_FULL;
                end else begin
                    cell_ctl.ins = start;
                    n_count      = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (pos_k >= cnt_k) begin
                    n_result.status = ST_RANGE;
                end else begin
                    cell_ctl.del = start;
                    n_count      = r_count - CW'(1);
                end
            end
            OP_PEEK: begin
                if (pos_k >= cnt_k) begin
                    n_result.status = ST_RANGE;
                end else begin
                    n_result.read_value = peek_or;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_result.entry_count = 5'(n_count);
        n_result.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_result <= n_result;
        end
    end

    assign busy     = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
